FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define EBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define EBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ebs_pkg.sv
// ---------------------------------------------------------------------------
// ebs_pkg
// Types and constants of the eyelid blink scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package ebs_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_FOLLOW_EYE   = 3'd0;
    localparam logic [2:0] REG_SAC_CHANCE   = 3'd1;
    localparam logic [2:0] REG_BLINK_LEN    = 3'd2;
    localparam logic [2:0] REG_PERIOD_LOW   = 3'd3;
    localparam logic [2:0] REG_PERIOD_HIGH  = 3'd4;
    localparam logic [2:0] REG_BLOCKED      = 3'd5;
    localparam logic [2:0] REG_LID_MIN      = 3'd6;
    localparam logic [2:0] REG_LID_MAX      = 3'd7;

    localparam logic              RST_FOLLOW_EYE  = 1'b1;
    localparam logic [15:0]       RST_SAC_CHANCE  = 16'd32768;
    localparam logic [15:0]       RST_BLINK_LEN   = 16'd150;
    localparam logic [15:0]       RST_PERIOD_LOW  = 16'd2000;
    localparam logic [15:0]       RST_PERIOD_HIGH = 16'd10000;
    localparam logic [15:0]       RST_BLOCKED     = 16'd1000;
    localparam logic signed [11:0] RST_LID_MIN    = -12'sd500;
    localparam logic signed [11:0] RST_LID_MAX    = 12'sd500;

    // closed lids sit ten degrees above the lower limit
    localparam logic signed [12:0] CLOSE_OFFSET = 13'sd100;
    localparam logic signed [12:0] SHUT_MAX     = 13'sd2047;

    typedef struct packed {
        logic                follow_eye;
        logic [15:0]         sac_chance;
        logic [15:0]         blink_len;
        logic [15:0]         period_low;
        logic [15:0]         period_high;
        logic [15:0]         blocked;
        logic signed [11:0]  lid_min;
        logic signed [11:0]  lid_max;
    } cfg_t;

    typedef struct packed {
        logic left_shut;
        logic right_shut;
    } blink_stat_t;

    // wrapping time compare: a is before b
    function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return diff[31];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ebs_targets.sv
// ---------------------------------------------------------------------------
// ebs_targets
// Lid target placement and clamping, plus the closed-lid angle.
// ---------------------------------------------------------------------------
`default_nettype none

module ebs_targets (
    input  wire ebs_pkg::cfg_t       cfg,
    input  wire logic signed [11:0]  eye_tilt,
    input  wire logic [10:0]         open_upper,
    input  wire logic [10:0]         open_lower,
    output logic signed [11:0]       upper,
    output logic signed [11:0]       lower,
    output logic signed [11:0]       shut
);

    logic signed [12:0] base;
    logic signed [12:0] up_raw;
    logic signed [12:0] lo_raw;
    logic signed [12:0] lmin;
    logic signed [12:0] lmax;
    logic signed [12:0] up_c;
    logic signed [12:0] lo_c;
    logic signed [12:0] shut_raw;

    always_comb
    begin
        base   = cfg.follow_eye ? 13'(eye_tilt) : 13'sd0;
        up_raw = base + $signed({2'b00, open_upper});
        lo_raw = base - $signed({2'b00, open_lower});
        lmin   = 13'(cfg.lid_min);
        lmax   = 13'(cfg.lid_max);

        // lower bound first, so the upper bound wins on inverted limits
        up_c = (up_raw < lmin) ? lmin : up_raw;
        if (up_c > lmax)
        begin
            up_c = lmax;
        end
        lo_c = (lo_raw < lmin) ? lmin : lo_raw;
        if (lo_c > lmax)
        begin
            lo_c = lmax;
        end

        shut_raw = lmin + ebs_pkg::CLOSE_OFFSET;
        if (shut_raw > ebs_pkg::SHUT_MAX)
        begin
            shut_raw = ebs_pkg::SHUT_MAX;
        end

        upper = up_c[11:0];
        lower = lo_c[11:0];
        shut  = shut_raw[11:0];
    end

endmodule

`default_nettype wire

FILE: rtl/ebs_blink.sv
// ---------------------------------------------------------------------------
// ebs_blink
// Blink state: saccade edge, requests, random and periodic blinks, timeouts.
// ---------------------------------------------------------------------------
`default_nettype none

module ebs_blink (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire ebs_pkg::cfg_t        cfg,
    input  wire logic signed [15:0]   request_left,
    input  wire logic signed [15:0]   request_right,
    input  wire logic                 saccade_now,
    input  wire logic [15:0]          chance_draw,
    input  wire logic [16:0]          interval,
    output ebs_pkg::blink_stat_t      stat
);

    logic [31:0] tick_reg;
    logic [31:0] tick_next;
    logic [31:0] end_reg [2];
    logic [31:0] end_next [2];
    logic [1:0]  on_reg;
    logic [1:0]  on_next;
    logic [1:0]  held_reg;
    logic [1:0]  held_next;
    logic [31:0] block_reg;
    logic [31:0] block_next;
    logic [31:0] periodic_reg;
    logic [31:0] periodic_next;
    logic        in_sac_reg;
    logic        in_sac_next;

    logic signed [15:0] rq [2];
    logic [31:0] bu_req;
    logic        open_win;
    logic        sac_go;
    logic        per_go;
    logic [31:0] auto_end;
    logic [1:0]  on_a;

    always_comb
    begin
        rq[0] = request_left;
        rq[1] = request_right;

        tick_next   = tick_reg + 32'd1;
        in_sac_next = saccade_now;
        held_next   = held_reg;
        on_a        = on_reg;
        end_next    = end_reg;

        bu_req   = (rq[0] != 16'sd0 || rq[1] != 16'sd0) ? tick_next : block_reg;
        open_win = !ebs_pkg::is_before(tick_next, bu_req);
        auto_end = tick_next + 32'(cfg.blink_len);

        for (int s = 0; s < 2; s++)
        begin
            if (rq[s][15])
            begin
                held_next[s] = 1'b1;
            end
            else if (rq[s] != 16'sd0)
            begin
                // a request always lands inside an open window
                end_next[s]  = tick_next + 32'($unsigned(rq[s][14:0]));
                on_a[s]      = 1'b1;
                held_next[s] = 1'b0;
            end
        end

        // pending saccade is handled in the same tick it is seen
        sac_go = saccade_now && !in_sac_reg && (chance_draw < cfg.sac_chance) && open_win;
        if (sac_go)
        begin
            on_a        = 2'b11;
            end_next[0] = auto_end;
            end_next[1] = auto_end;
        end

        periodic_next = (on_a != 2'b00) ? tick_next + 32'(interval) : periodic_reg;
        per_go = ebs_pkg::is_before(periodic_next, tick_next) && open_win;
        on_next = on_a;
        if (per_go)
        begin
            on_next     = 2'b11;
            end_next[0] = auto_end;
            end_next[1] = auto_end;
        end

        for (int s = 0; s < 2; s++)
        begin
            if (!ebs_pkg::is_before(tick_next, end_next[s]))
            begin
                on_next[s] = 1'b0;
            end
        end

        block_next = (on_next != 2'b00) ? tick_next + 32'(cfg.blocked) : bu_req;

        stat.left_shut  = on_next[0] | held_next[0];
        stat.right_shut = on_next[1] | held_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            end_reg[0]   <= '0;
            end_reg[1]   <= '0;
            on_reg       <= '0;
            held_reg     <= '0;
            block_reg    <= '0;
            periodic_reg <= '0;
            in_sac_reg   <= 1'b0;
        end
        else if (step)
        begin
            tick_reg     <= tick_next;
            end_reg      <= end_next;
            on_reg       <= on_next;
            held_reg     <= held_next;
            block_reg    <= block_next;
            periodic_reg <= periodic_next;
            in_sac_reg   <= in_sac_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/eyelid_blink_scheduler.sv
// ---------------------------------------------------------------------------
// eyelid_blink_scheduler
// Per-millisecond lid target and blink scheduling with valid/ready channels.
// ---------------------------------------------------------------------------
//  channel  | handshake                 | beat
//  ---------+---------------------------+----------------------------------
//  config   | cfg_we                    | cfg_index, cfg_data
//  item     | item_valid / item_ready   | tilt, openings, requests, draws
//  result   | result_valid / result_ready | four lid targets, shut flags
//
//  One beat per cycle while the result channel is not stalled. A beat is first
//  held in the input register (the interval multiply lands there) and then
//  moves into the result register, which drives the result handshake.
//  The blink state advances when a beat moves into the result register.
//  Reset clears the valid flags and blink state and loads the register
//  defaults. A stalled result holds the input register; input is still
//  taken while the result register is free or being drained.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module eyelid_blink_scheduler (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire logic signed [11:0]  eye_tilt,
    input  wire logic [10:0]         open_upper,
    input  wire logic [10:0]         open_lower,
    input  wire logic signed [15:0]  request_left,
    input  wire logic signed [15:0]  request_right,
    input  wire logic                saccade_now,
    input  wire logic [15:0]         chance_draw,
    input  wire logic [15:0]         interval_draw,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic signed [11:0]       upper_left,
    output logic signed [11:0]       lower_left,
    output logic signed [11:0]       upper_right,
    output logic signed [11:0]       lower_right,
    output logic                     left_shut,
    output logic                     right_shut
);

    ebs_pkg::cfg_t cfg_reg;

    // input register
    logic               s1_valid_reg;
    logic signed [11:0] s1_tilt_reg;
    logic [10:0]        s1_ou_reg;
    logic [10:0]        s1_ol_reg;
    logic signed [15:0] s1_rql_reg;
    logic signed [15:0] s1_rqr_reg;
    logic               s1_sac_reg;
    logic [15:0]        s1_cdraw_reg;
    logic [16:0]        s1_iv_reg;

    // result register
    logic               res_valid_reg;
    logic signed [11:0] res_ul_reg;
    logic signed [11:0] res_ll_reg;
    logic signed [11:0] res_ur_reg;
    logic signed [11:0] res_lr_reg;
    logic               res_ls_reg;
    logic               res_rs_reg;

    logic               advance;
    logic               accept;
    logic [15:0]        span;
    logic [31:0]        product;
    logic [16:0]        iv_next;
    logic signed [11:0] tgt_upper;
    logic signed [11:0] tgt_lower;
    logic signed [11:0] tgt_shut;
    ebs_pkg::blink_stat_t stat;

    assign advance    = s1_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign accept     = item_valid && item_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.follow_eye  <= ebs_pkg::RST_FOLLOW_EYE;
            cfg_reg.sac_chance  <= ebs_pkg::RST_SAC_CHANCE;
            cfg_reg.blink_len   <= ebs_pkg::RST_BLINK_LEN;
            cfg_reg.period_low  <= ebs_pkg::RST_PERIOD_LOW;
            cfg_reg.period_high <= ebs_pkg::RST_PERIOD_HIGH;
            cfg_reg.blocked     <= ebs_pkg::RST_BLOCKED;
            cfg_reg.lid_min     <= ebs_pkg::RST_LID_MIN;
            cfg_reg.lid_max     <= ebs_pkg::RST_LID_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ebs_pkg::REG_FOLLOW_EYE:  cfg_reg.follow_eye  <= cfg_data[0];
                ebs_pkg::REG_SAC_CHANCE:  cfg_reg.sac_chance  <= cfg_data;
                ebs_pkg::REG_BLINK_LEN:   cfg_reg.blink_len   <= cfg_data;
                ebs_pkg::REG_PERIOD_LOW:  cfg_reg.period_low  <= cfg_data;
                ebs_pkg::REG_PERIOD_HIGH: cfg_reg.period_high <= cfg_data;
                ebs_pkg::REG_BLOCKED:     cfg_reg.blocked     <= cfg_data;
                ebs_pkg::REG_LID_MIN:     cfg_reg.lid_min     <= $signed(cfg_data[11:0]);
                ebs_pkg::REG_LID_MAX:     cfg_reg.lid_max     <= $signed(cfg_data[11:0]);
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // periodic interval, worked out on the way into the input register
    always_comb
    begin
        span    = cfg_reg.period_high - cfg_reg.period_low;
        product = span * interval_draw;
        if (cfg_reg.period_high > cfg_reg.period_low)
        begin
            iv_next = {1'b0, cfg_reg.period_low} + {1'b0, product[31:16]};
        end
        else
        begin
            iv_next = {1'b0, cfg_reg.period_low};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tilt_reg  <= eye_tilt;
            s1_ou_reg    <= open_upper;
            s1_ol_reg    <= open_lower;
            s1_rql_reg   <= request_left;
            s1_rqr_reg   <= request_right;
            s1_sac_reg   <= saccade_now;
            s1_cdraw_reg <= chance_draw;
            s1_iv_reg    <= iv_next;
        end
    end

    ebs_targets u_targets (
        .cfg        (cfg_reg),
        .eye_tilt   (s1_tilt_reg),
        .open_upper (s1_ou_reg),
        .open_lower (s1_ol_reg),
        .upper      (tgt_upper),
        .lower      (tgt_lower),
        .shut       (tgt_shut)
    );

    ebs_blink u_blink (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .cfg           (cfg_reg),
        .request_left  (s1_rql_reg),
        .request_right (s1_rqr_reg),
        .saccade_now   (s1_sac_reg),
        .chance_draw   (s1_cdraw_reg),
        .interval      (s1_iv_reg),
        .stat          (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_ul_reg <= stat.left_shut  ? tgt_shut : tgt_upper;
            res_ll_reg <= stat.left_shut  ? tgt_shut : tgt_lower;
            res_ur_reg <= stat.right_shut ? tgt_shut : tgt_upper;
            res_lr_reg <= stat.right_shut ? tgt_shut : tgt_lower;
            res_ls_reg <= stat.left_shut;
            res_rs_reg <= stat.right_shut;
        end
    end

    assign result_valid = res_valid_reg;
    assign upper_left   = res_ul_reg;
    assign lower_left   = res_ll_reg;
    assign upper_right  = res_ur_reg;
    assign lower_right  = res_lr_reg;
    assign left_shut    = res_ls_reg;
    assign right_shut   = res_rs_reg;

    // closed side drives both lids to the same angle
    `EBS_ASSERT_SAME(a_left_closed_pair, clk, rst_n, result_valid && left_shut, upper_left == lower_left, "left lids differ while shut")
    `EBS_ASSERT_SAME(a_right_closed_pair, clk, rst_n, result_valid && right_shut, upper_right == lower_right, "right lids differ while shut")
    // an accepted beat must be held in the input register next cycle
    `EBS_ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, s1_valid_reg, "accepted beat lost")
    // a moved beat always produces a result
    `EBS_ASSERT_NEXT(a_advance_result, clk, rst_n, advance, res_valid_reg, "advanced beat not shown")

endmodule

`default_nettype wire
